// ----- design/nrcm_pkg.sv -----
// nrcm_pkg: shared types, constants and functions for the coordinate mapper.
// No dependencies.
package nrcm_pkg;

   localparam int MaxEntries = 8;
   localparam int SlotW = $clog2(MaxEntries);
   localparam int FracBits = 8;
   localparam logic signed [25:0] OneUnit = 26'sd1 <<< FracBits;
   localparam logic [15:0] ScaleOne = 16'd4096;
   localparam int QDepth = 2;

   localparam logic [2:0] KIND_WRITE = 3'd0;
   localparam logic [2:0] KIND_P2S = 3'd1;
   localparam logic [2:0] KIND_S2P = 3'd2;
   localparam logic [2:0] KIND_P2S_SLOT = 3'd3;
   localparam logic [2:0] KIND_S2P_SLOT = 3'd4;

   localparam logic [1:0] CSR_MONITOR_COUNT = 2'd0;
   localparam logic [1:0] CSR_FORCE_ZERO = 2'd1;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] slot;
      logic signed [23:0] primary_x;
      logic signed [23:0] primary_y;
      logic signed [23:0] secondary_x;
      logic signed [23:0] secondary_y;
      logic [22:0] logical_width;
      logic [22:0] logical_height;
      logic [22:0] transformed_width;
      logic [22:0] transformed_height;
      logic [15:0] scale_factor;
   } req_type;

   typedef struct packed {
      logic found;
      logic [2:0] chosen_slot;
      logic signed [23:0] mapped_x;
      logic signed [23:0] mapped_y;
      logic saturated;
   } rsp_type;

   // Classified job passed from front to back.
   typedef struct packed {
      logic to_sec;
      logic search;
      logic slot_ok;
      logic [SlotW-1:0] slot;
      logic signed [23:0] px;
      logic signed [23:0] py;
   } job_type;

   typedef struct packed {
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic [22:0] lw;
      logic [22:0] lh;
      logic [22:0] tw;
      logic [22:0] th;
      logic [15:0] sc;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_MAP, ST_DIV, ST_ADD, ST_OUT
   } back_state_type;

   function automatic logic signed [25:0] axis_gap(input logic signed [23:0] p,
         input logic signed [23:0] lo, input logic [22:0] size);
      logic signed [25:0] hi;
      logic signed [25:0] g;
      hi = 26'(lo) + 26'(signed'({1'b0, size})) - OneUnit;
      g = '0;
      if (26'(lo) - 26'(p) > g) g = 26'(lo) - 26'(p);
      if (26'(p) - hi > g) g = 26'(p) - hi;
      return g;
   endfunction

endpackage

// ----- design/nearest_rect_coord_mapper_unit.sv -----
// Top level of the nearest-rectangle coordinate mapper.
// Search maps scan min(count,8) table entries, slot maps skip the search; with zero-scaling in
//   the secondary-to-primary direction a serial divider runs on the x and then the y offset.
// The single back-end engine takes a new map item only once the last is done and its result
//   popped; a write is accepted once no earlier map is queued or running.
//   Synchronous reset clears the control state and config registers; the entry table holds no reset value.
// Depends on nrcm_pkg, nrcm_front, nrcm_queue, nrcm_back.
module nearest_rect_coord_mapper_unit import nrcm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic push,
   output logic full,
   input  req_type req_data,
   output logic empty,
   input  logic pop,
   output rsp_type rsp_data,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_data
);
   logic [3:0] count_ff;
   logic fz_ff;
   logic q_wr, q_full, q_rd, q_empty;
   logic back_busy;
   job_type wjob, rjob;
   logic tbl_we;
   logic [SlotW-1:0] tbl_addr;
   entry_type tbl_entry;

   assign csr_ready = 1'b1;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         fz_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_MONITOR_COUNT: count_ff <= csr_data[3:0];
            CSR_FORCE_ZERO: fz_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   nrcm_front u_front (.req_push(push), .req_full(full), .req_data,
      .count(count_ff), .q_full, .q_empty, .back_busy, .q_wr, .q_job(wjob), .tbl_we,
      .tbl_addr, .tbl_entry);

   nrcm_queue u_queue (.clock, .reset, .wr(q_wr), .wr_job(wjob), .full(q_full),
      .rd(q_rd), .empty(q_empty), .rd_job(rjob));

   nrcm_back u_back (.clock, .reset, .count(count_ff), .fz(fz_ff), .tbl_we, .tbl_addr,
      .tbl_entry, .q_empty, .q_job(rjob), .q_rd, .busy(back_busy), .rsp_empty(empty),
      .rsp_pop(pop), .rsp_data);
endmodule

// ----- design/nrcm_front.sv -----
// nrcm_front: accepts items, performs table writes, classifies map items.
// Depends on nrcm_pkg.
module nrcm_front import nrcm_pkg::*; (
   input  logic req_push,
   output logic req_full,
   input  req_type req_data,
   input  logic [3:0] count,
   input  logic q_full,
   input  logic q_empty,
   input  logic back_busy,
   output logic q_wr,
   output job_type q_job,
   output logic tbl_we,
   output logic [SlotW-1:0] tbl_addr,
   output entry_type tbl_entry
);
   logic acc;
   logic is_map;

   // a table write waits until every earlier map has finished with the table
   assign req_full = q_full
      || (req_data.kind == KIND_WRITE && (back_busy || !q_empty));
   assign acc = req_push && !req_full;
   assign is_map = req_data.kind == KIND_P2S || req_data.kind == KIND_S2P
      || req_data.kind == KIND_P2S_SLOT || req_data.kind == KIND_S2P_SLOT;

   assign q_wr = acc && is_map;
   assign tbl_we = acc && req_data.kind == KIND_WRITE;
   assign tbl_addr = req_data.slot[SlotW-1:0];
   assign tbl_entry = '{px: req_data.primary_x, py: req_data.primary_y,
      sx: req_data.secondary_x, sy: req_data.secondary_y,
      lw: req_data.logical_width, lh: req_data.logical_height,
      tw: req_data.transformed_width, th: req_data.transformed_height,
      sc: req_data.scale_factor};

   always_comb begin
      q_job.to_sec = req_data.kind == KIND_P2S || req_data.kind == KIND_P2S_SLOT;
      q_job.search = req_data.kind == KIND_P2S || req_data.kind == KIND_S2P;
      q_job.slot_ok = {1'b0, req_data.slot} < count;
      q_job.slot = req_data.slot[SlotW-1:0];
      q_job.px = q_job.to_sec ? req_data.primary_x : req_data.secondary_x;
      q_job.py = q_job.to_sec ? req_data.primary_y : req_data.secondary_y;
   end
endmodule

// ----- design/nrcm_queue.sv -----
// nrcm_queue: short job queue between front and back.
// Depends on nrcm_pkg.
module nrcm_queue import nrcm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic wr,
   input  job_type wr_job,
   output logic full,
   input  logic rd,
   output logic empty,
   output job_type rd_job
);
   job_type mem_ff [QDepth];
   logic [0:0] wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full = cnt_ff == 2'(QDepth);
   assign empty = cnt_ff == 2'd0;
   assign rd_job = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr) mem_ff[wp_ff] <= wr_job;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 1'b1;
         if (rd) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !wr)
      else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset) empty |-> !rd)
      else $error("queue underflow");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'(QDepth))
      else $error("queue count out of range");
endmodule

// ----- design/nrcm_back.sv -----
// nrcm_back: holds the entry table, searches, maps and buffers one result.
// Depends on nrcm_pkg.
module nrcm_back import nrcm_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [3:0] count,
   input  logic fz,
   input  logic tbl_we,
   input  logic [SlotW-1:0] tbl_addr,
   input  entry_type tbl_entry,
   input  logic q_empty,
   input  job_type q_job,
   output logic q_rd,
   output logic busy,
   output logic rsp_empty,
   input  logic rsp_pop,
   output rsp_type rsp_data
);
   entry_type tbl_ff [MaxEntries];

   back_state_type st_ff, st_in;
   job_type job_ff;
   logic [SlotW:0] idx_ff, idx_in;
   logic [SlotW-1:0] pick_ff, pick_in;
   logic found_ff, found_in;
   logic [50:0] bd_ff, bd_in;
   logic [51:0] bc_ff, bc_in;
   logic signed [24:0] dx_ff, dy_ff, dx_in, dy_in;
   logic signed [41:0] mx_ff, my_ff;
   // divider
   logic [40:0] rem_ff, quo_ff;
   logic [5:0] dcnt_ff;
   logic dsel_ff;
   logic signed [41:0] ddx_ff;
   rsp_type out_ff;
   logic out_v_ff;

   logic [3:0] cnt_lim;
   entry_type e;
   entry_type ps;
   logic signed [23:0] sx, sy;
   logic [22:0] szx, szy;
   logic signed [25:0] gx, gy;
   logic signed [27:0] cx, cy;
   logic [50:0] d;
   logic [51:0] c;
   logic [15:0] sc;
   logic signed [41:0] prod_x, prod_y;
   logic [41:0] trial;

   assign cnt_lim = count > 4'(MaxEntries) ? 4'(MaxEntries) : count;

   always_ff @(posedge clock) begin
      if (tbl_we) tbl_ff[tbl_addr] <= tbl_entry;
   end

   always_comb begin
      e = tbl_ff[idx_ff[SlotW-1:0]];
      sx = job_ff.to_sec ? e.px : e.sx;
      sy = job_ff.to_sec ? e.py : e.sy;
      szx = fz ? e.tw : e.lw;
      szy = fz ? e.th : e.lh;
      gx = axis_gap(job_ff.px, sx, szx);
      gy = axis_gap(job_ff.py, sy, szy);
      d = 51'(gx * gx) + 51'(gy * gy);
      cx = 28'(2 * 28'(job_ff.px)) - 28'(2 * 28'(sx)) - 28'(signed'({1'b0, szx}));
      cy = 28'(2 * 28'(job_ff.py)) - 28'(2 * 28'(sy)) - 28'(signed'({1'b0, szy}));
      c = 52'(cx * cx) + 52'(cy * cy);
      ps = tbl_ff[pick_ff];
      sc = ps.sc == 16'd0 ? 16'd1 : ps.sc;
      prod_x = 42'(dx_ff) * 42'(signed'({1'b0, sc}));
      prod_y = 42'(dy_ff) * 42'(signed'({1'b0, sc}));
      trial = {rem_ff, quo_ff[40]};
   end

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      pick_in = pick_ff;
      found_in = found_ff;
      bd_in = bd_ff;
      bc_in = bc_ff;
      dx_in = dx_ff;
      dy_in = dy_ff;
      q_rd = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (!q_empty && !out_v_ff) begin
               q_rd = 1'b1;
               idx_in = '0;
               found_in = !q_job.search && q_job.slot_ok;
               pick_in = q_job.slot;
               st_in = q_job.search ? ST_SEARCH : ST_MAP;
            end
         end
         ST_SEARCH: begin
            if (idx_ff >= cnt_lim) begin
               st_in = ST_MAP;
            end else begin
               if (!found_ff || d < bd_ff || (d == bd_ff && c < bc_ff)) begin
                  found_in = 1'b1;
                  pick_in = idx_ff[SlotW-1:0];
                  bd_in = d;
                  bc_in = c;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_MAP: begin
            dx_in = 25'(job_ff.px) - 25'(job_ff.to_sec ? ps.px : ps.sx);
            dy_in = 25'(job_ff.py) - 25'(job_ff.to_sec ? ps.py : ps.sy);
            st_in = ST_DIV;
         end
         ST_DIV: begin
            // divider only ends on the y pass
            if (!fz || job_ff.to_sec || (dcnt_ff == 6'd42 && dsel_ff)) st_in = ST_ADD;
         end
         ST_ADD: st_in = ST_OUT;
         ST_OUT: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         out_v_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (st_ff == ST_OUT) out_v_ff <= 1'b1;
         else if (rsp_pop && out_v_ff) out_v_ff <= 1'b0;
      end
      idx_ff <= idx_in;
      pick_ff <= pick_in;
      found_ff <= found_in;
      bd_ff <= bd_in;
      bc_ff <= bc_in;
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      if (q_rd) job_ff <= q_job;
      // offset scaling: pass-through, multiply by s/4096, or serial restoring divide on |d|*4096 / s, x then y
      if (st_ff == ST_MAP) begin
         dcnt_ff <= '0;
         dsel_ff <= 1'b0;
      end else if (st_ff == ST_DIV) begin
         if (!fz) begin
            mx_ff <= 42'(dx_ff);
            my_ff <= 42'(dy_ff);
         end else if (job_ff.to_sec) begin
            mx_ff <= prod_x / 42'sd4096;
            my_ff <= prod_y / 42'sd4096;
         end else if (dcnt_ff == 6'd0) begin
            ddx_ff <= 42'(dx_ff);
            rem_ff <= '0;
            quo_ff <= 41'(dx_ff < 0 ? -dx_ff : dx_ff) << 12;
            dcnt_ff <= 6'd1;
         end else if (dcnt_ff <= 6'd41) begin
            if (trial >= 42'(sc)) begin
               rem_ff <= 41'(trial - 42'(sc));
               quo_ff <= {quo_ff[39:0], 1'b1};
            end else begin
               rem_ff <= trial[40:0];
               quo_ff <= {quo_ff[39:0], 1'b0};
            end
            dcnt_ff <= dcnt_ff + 6'd1;
         end else begin
            if (!dsel_ff) begin
               mx_ff <= ddx_ff < 0 ? -42'(quo_ff) : 42'(quo_ff);
               dsel_ff <= 1'b1;
               ddx_ff <= 42'(dy_ff);
               rem_ff <= '0;
               quo_ff <= 41'(dy_ff < 0 ? -dy_ff : dy_ff) << 12;
               dcnt_ff <= 6'd1;
            end else begin
               my_ff <= ddx_ff < 0 ? -42'(quo_ff) : 42'(quo_ff);
            end
         end
      end else if (st_ff == ST_ADD) begin
         mx_ff <= mx_ff + 42'(job_ff.to_sec ? ps.sx : ps.px);
         my_ff <= my_ff + 42'(job_ff.to_sec ? ps.sy : ps.py);
      end
      if (st_ff == ST_OUT) begin
         out_ff.found <= found_ff;
         out_ff.chosen_slot <= found_ff ? 3'(pick_ff) : 3'd0;
         out_ff.mapped_x <= !found_ff ? 24'sd0 : mx_ff > 42'sd8388607 ? 24'sd8388607 :
            mx_ff < -42'sd8388608 ? -24'sd8388608 : mx_ff[23:0];
         out_ff.mapped_y <= !found_ff ? 24'sd0 : my_ff > 42'sd8388607 ? 24'sd8388607 :
            my_ff < -42'sd8388608 ? -24'sd8388608 : my_ff[23:0];
         out_ff.saturated <= found_ff && (mx_ff > 42'sd8388607 || mx_ff < -42'sd8388608
            || my_ff > 42'sd8388607 || my_ff < -42'sd8388608);
      end
   end

   assign busy = st_ff != ST_IDLE;
   assign rsp_empty = !out_v_ff;
   assign rsp_data = out_ff;

   assert property (@(posedge clock) disable iff (reset) q_rd |-> !out_v_ff)
      else $error("started job with result pending");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT) |=> out_v_ff)
      else $error("result lost");
   assert property (@(posedge clock) disable iff (reset)
      (st_ff != ST_IDLE) |-> !q_rd)
      else $error("dequeue while busy");
endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for nearest_rect_coord_mapper_unit.
// Depends on nrcm_pkg and the mapper RTL. Drives table writes and map requests,
// predicts each map result in place and checks it field by field.
module testbench;
   import nrcm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 20000;   // cycles without any transfer
   localparam int DrainWait = 150;     // longest map latency plus margin
   localparam longint C24Max = 8388607;
   localparam longint C24Min = -8388608;
   localparam longint ScaleMul = longint'(ScaleOne);

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic pop = 1'b0;
   logic full, empty, csr_ready;
   logic csr_valid = 1'b0;
   logic [1:0] csr_index = CSR_MONITOR_COUNT;
   logic [31:0] csr_data = '0;
   req_type req_data = '0;
   rsp_type rsp_data;

   // Shadow copy of the entry table and the registers.
   longint pri_pos [MaxEntries][2];
   longint sec_pos [MaxEntries][2];
   longint log_size [MaxEntries][2];
   longint xf_size [MaxEntries][2];
   longint scale_tab [MaxEntries];
   int unsigned mon_count = 0;
   bit zero_scaling = 1'b0;

   rsp_type expected_maps[$];
   int unsigned fail_count = 0;
   int unsigned maps_checked = 0;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   bit no_gaps = 1'b0;   // when set, neither side idles

   always #2 clock = ~clock;

   nearest_rect_coord_mapper_unit u_top (
      .clock(clock), .reset(reset), .push(push), .full(full), .req_data(req_data),
      .empty(empty), .pop(pop), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   // Mostly short gaps, a few long ones.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic longint clamp_coord(longint v, ref bit sat);
      if (v > C24Max) begin
         sat = 1'b1;
         return C24Max;
      end
      if (v < C24Min) begin
         sat = 1'b1;
         return C24Min;
      end
      return v;
   endfunction

   function automatic longint edge_gap(longint p, longint lo, longint sz);
      longint hi, g;
      hi = lo + sz - (longint'(1) << FracBits);
      g = 0;
      if (lo - p > g) g = lo - p;
      if (p - hi > g) g = p - hi;
      return g;
   endfunction

   // Applies one accepted item to the shadow table; returns 1 with the
   // predicted result when the item is a map.
   function automatic bit predict_map(req_type it, output rsp_type res);
      int unsigned cnt, pick;
      bit to_sec, hit, sat;
      longint px, py, dx, dy, s, d, c, best_d, best_c, mx, my;
      longint src [MaxEntries][2];
      longint dst [MaxEntries][2];
      longint sz [MaxEntries][2];
      res = '0;
      if (it.kind == KIND_WRITE) begin
         pri_pos[it.slot][0] = longint'(it.primary_x);
         pri_pos[it.slot][1] = longint'(it.primary_y);
         sec_pos[it.slot][0] = longint'(it.secondary_x);
         sec_pos[it.slot][1] = longint'(it.secondary_y);
         log_size[it.slot][0] = longint'(it.logical_width);
         log_size[it.slot][1] = longint'(it.logical_height);
         xf_size[it.slot][0] = longint'(it.transformed_width);
         xf_size[it.slot][1] = longint'(it.transformed_height);
         scale_tab[it.slot] = longint'(it.scale_factor);
         return 1'b0;
      end
      if (it.kind > KIND_S2P_SLOT) return 1'b0;
      cnt = (mon_count < MaxEntries) ? mon_count : MaxEntries;
      to_sec = (it.kind == KIND_P2S || it.kind == KIND_P2S_SLOT);
      px = to_sec ? longint'(it.primary_x) : longint'(it.secondary_x);
      py = to_sec ? longint'(it.primary_y) : longint'(it.secondary_y);
      if (to_sec) begin
         src = pri_pos;
         dst = sec_pos;
      end else begin
         src = sec_pos;
         dst = pri_pos;
      end
      if (zero_scaling) sz = xf_size;
      else sz = log_size;
      hit = 1'b0;
      pick = 0;
      best_d = 0;
      best_c = 0;
      sat = 1'b0;
      if (it.kind >= KIND_P2S_SLOT) begin
         if (it.slot < cnt) begin
            hit = 1'b1;
            pick = it.slot;
         end
      end else begin
         for (int i = 0; i < cnt; i++) begin
            d = edge_gap(px, src[i][0], sz[i][0]) ** 2 + edge_gap(py, src[i][1], sz[i][1]) ** 2;
            c = (2 * px - 2 * src[i][0] - sz[i][0]) ** 2
              + (2 * py - 2 * src[i][1] - sz[i][1]) ** 2;
            if (!hit || d < best_d || (d == best_d && c < best_c)) begin
               hit = 1'b1;
               pick = i;
               best_d = d;
               best_c = c;
            end
         end
      end
      if (hit) begin
         dx = px - src[pick][0];
         dy = py - src[pick][1];
         if (zero_scaling) begin
            s = (scale_tab[pick] == 0) ? 1 : scale_tab[pick];
            if (to_sec) begin
               dx = (dx * s) / ScaleMul;
               dy = (dy * s) / ScaleMul;
            end else begin
               dx = (dx * ScaleMul) / s;
               dy = (dy * ScaleMul) / s;
            end
         end
         mx = clamp_coord(dx + dst[pick][0], sat);
         my = clamp_coord(dy + dst[pick][1], sat);
         res.found = 1'b1;
         res.chosen_slot = pick[2:0];
         res.mapped_x = mx[23:0];
         res.mapped_y = my[23:0];
         res.saturated = sat;
      end
      return 1'b1;
   endfunction

   // Sends one item through the push/full handshake and records its outcome.
   task automatic send_item(req_type it);
      int gap;
      rsp_type res;
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (full);
      items_sent++;
      if (predict_map(it, res)) expected_maps.push_back(res);
   endtask

   // Register write, only once the block has drained.
   task automatic write_csr(logic [1:0] idx, logic [31:0] val);
      push <= 1'b0;
      wait (expected_maps.size() == 0);
      repeat (DrainWait) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MONITOR_COUNT) mon_count = val[3:0];
      else zero_scaling = val[0];
   endtask

   function automatic logic signed [23:0] rand_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 24'sh7FFFFF;
      if (r == 1) return 24'sh800000;
      if (r < 5) return 24'($urandom());
      return 24'($signed($urandom_range(0, 40000)) - 20000);
   endfunction

   function automatic logic [22:0] rand_size();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 23'h7FFFFF;
      if (r == 1) return '0;
      if (r < 4) return 23'($urandom());
      return 23'($urandom_range(0, 6000));
   endfunction

   function automatic req_type rand_entry(logic [2:0] slot);
      req_type it;
      it.kind = KIND_WRITE;
      it.slot = slot;
      it.primary_x = rand_coord();
      it.primary_y = rand_coord();
      it.secondary_x = rand_coord();
      it.secondary_y = rand_coord();
      it.logical_width = rand_size();
      it.logical_height = rand_size();
      it.transformed_width = rand_size();
      it.transformed_height = rand_size();
      it.scale_factor = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                    : 16'($urandom_range(1024, 12288));
      return it;
   endfunction

   // Query point mostly around a stored rectangle, sometimes anywhere.
   function automatic req_type rand_query();
      req_type it;
      int unsigned e;
      longint qx, qy;
      bit dummy;
      it = rand_entry(3'($urandom()));
      it.kind = 3'($urandom_range(KIND_P2S, KIND_S2P_SLOT));
      e = $urandom_range(0, MaxEntries - 1);
      if ($urandom_range(0, 3) != 0) begin
         dummy = 1'b0;
         qx = (it.kind == KIND_P2S || it.kind == KIND_P2S_SLOT) ? pri_pos[e][0] : sec_pos[e][0];
         qy = (it.kind == KIND_P2S || it.kind == KIND_P2S_SLOT) ? pri_pos[e][1] : sec_pos[e][1];
         qx = clamp_coord(qx + $signed($urandom_range(0, 16000)) - 4000, dummy);
         qy = clamp_coord(qy + $signed($urandom_range(0, 16000)) - 4000, dummy);
         it.primary_x = qx[23:0];
         it.primary_y = qy[23:0];
         it.secondary_x = qx[23:0];
         it.secondary_y = qy[23:0];
      end
      return it;
   endfunction

   // Every slot gets written before anything can read it.
   task automatic test_fill_table();
      for (int i = 0; i < MaxEntries; i++) send_item(rand_entry(3'(i)));
   endtask

   task automatic test_directed();
      req_type it;
      // monitor count of zero: search and slot maps both report not found
      write_csr(CSR_MONITOR_COUNT, 0);
      for (int k = KIND_P2S; k <= KIND_S2P_SLOT; k++) begin
         it = rand_query();
         it.kind = 3'(k);
         send_item(it);
      end
      write_csr(CSR_MONITOR_COUNT, 3);
      // slot at and above the count, slot below it
      it = rand_query();
      it.kind = KIND_P2S_SLOT;
      it.slot = 3'd3;
      send_item(it);
      it.kind = KIND_S2P_SLOT;
      it.slot = 3'd7;
      send_item(it);
      it.slot = 3'd2;
      send_item(it);
      // zero logical width, zero transformed height and zero scale, identical twin in slot 1 for a tie
      it = rand_entry(3'd0);
      it.logical_width = '0;
      it.transformed_height = '0;
      it.scale_factor = '0;
      send_item(it);
      it.slot = 3'd1;
      send_item(it);
      // ignored kinds produce nothing
      for (int k = 5; k <= 7; k++) begin
         it.kind = 3'(k);
         send_item(it);
      end
      // extreme points in both directions, with and without scaling
      for (int z = 0; z < 2; z++) begin
         write_csr(CSR_FORCE_ZERO, z);
         for (int k = KIND_P2S; k <= KIND_S2P_SLOT; k++) begin
            it = rand_query();
            it.kind = 3'(k);
            it.slot = 3'd0;
            {it.primary_x, it.secondary_y} = {24'sh7FFFFF, 24'sh800000};
            {it.primary_y, it.secondary_x} = {24'sh800000, 24'sh7FFFFF};
            send_item(it);
         end
      end
   endtask

   task automatic test_random_phase(int unsigned cnt, bit fz, int unsigned n);
      int r;
      req_type it;
      write_csr(CSR_MONITOR_COUNT, cnt);
      write_csr(CSR_FORCE_ZERO, fz);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int unsigned i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 20) send_item(rand_entry(3'($urandom())));
         else if (r < 24) begin
            // ignored kind
            it = rand_entry(3'($urandom()));
            it.kind = 3'($urandom_range(5, 7));
            send_item(it);
         end else send_item(rand_query());
      end
      no_gaps = 1'b0;
   endtask

   // Result side: random pop pattern and the check of each transfer.
   always @(posedge clock) begin
      rsp_type want;
      pop <= (pick_gap() == 0);
      if (!reset && pop && !empty) begin
         if (expected_maps.size() == 0) begin
            $error("unexpected result transfer: %p", rsp_data);
            fail_count++;
         end else begin
            want = expected_maps.pop_front();
            maps_checked++;
            if (rsp_data.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_data.found);
               fail_count++;
            end
            if (rsp_data.chosen_slot !== want.chosen_slot) begin
               $error("chosen_slot: expected %0d, got %0d", want.chosen_slot,
                      rsp_data.chosen_slot);
               fail_count++;
            end
            if (rsp_data.mapped_x !== want.mapped_x) begin
               $error("mapped_x: expected %0d, got %0d", want.mapped_x, rsp_data.mapped_x);
               fail_count++;
            end
            if (rsp_data.mapped_y !== want.mapped_y) begin
               $error("mapped_y: expected %0d, got %0d", want.mapped_y, rsp_data.mapped_y);
               fail_count++;
            end
            if (rsp_data.saturated !== want.saturated) begin
               $error("saturated: expected %0d, got %0d", want.saturated,
                      rsp_data.saturated);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= IdleLimit) begin
         $display("tb: failure");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      for (int i = 0; i < MaxEntries; i++) begin
         scale_tab[i] = 0;
         for (int a = 0; a < 2; a++) begin
            pri_pos[i][a] = 0;
            sec_pos[i][a] = 0;
            log_size[i][a] = 0;
            xf_size[i][a] = 0;
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_table();
      test_directed();
      test_random_phase(8, 1'b0, 260);
      test_random_phase(8, 1'b1, 260);
      test_random_phase(1, 1'b1, 200);
      test_random_phase(15, 1'b0, 260);
      test_random_phase(5, 1'b1, 260);
      test_random_phase(0, 1'b0, 60);
      test_random_phase(8, 1'b1, 250);
      push <= 1'b0;
      wait (expected_maps.size() == 0);
      repeat (DrainWait) @(posedge clock);
      $display("Sent %0d items over counts 0..15 with scaling off and on; %0d maps checked.",
               items_sent, maps_checked);
      if (fail_count == 0 && expected_maps.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
